/* design/upce_pkg.sv */
package upce_pkg;

    typedef enum logic [1:0] {
        MODE_ENCODE  = 2'd0,
        MODE_DECODE  = 2'd1,
        MODE_UNQUOTE = 2'd2,
        MODE_REQUOTE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One coded group of up to three output bytes.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } cmd_t;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    function automatic logic is_unreserved(input logic [7:0] c);
        logic alnum;
        alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h30 && c <= 8'h39);
        return alnum || c == 8'h2D || c == 8'h2E || c == 8'h5F || c == 8'h7E ||
               c == 8'h00;
    endfunction

    function automatic logic is_reserved(input logic [7:0] c);
        logic r;
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
            8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D,
            8'h7E: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Uppercase hex character for a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib > 4'd9)
            d = {4'd0, nib} + 8'h37;
        else
            d = {4'd0, nib} + 8'h30;
        return d;
    endfunction

    // Invalid characters count as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= 8'h30 && c <= 8'h39)
            t = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            t = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46)
            t = c - 8'h37;
        return t[3:0];
    endfunction

endpackage

/* design/upce_front.sv */
module upce_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        coding_mode,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    input  logic              q_full,
    output logic              q_push,
    output upce_pkg::cmd_t    q_cmd
);
    import upce_pkg::*;

    mode_t      mode_reg, mode_next;
    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    logic       plus_sp;
    logic [7:0] plain;
    logic [7:0] dec_val;
    logic       enc_mode;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign enc_mode  = (mode_reg == MODE_ENCODE) || (mode_reg == MODE_REQUOTE);
    assign plus_sp   = (mode_reg == MODE_DECODE) && (in_byte == CH_PLUS);
    assign plain     = plus_sp ? CH_SPACE : in_byte;
    assign dec_val   = {hex_value(held_reg), hex_value(in_byte)};

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        if (cfg_valid)
        begin
            mode_next  = mode_t'(coding_mode);
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end
        else if (accept)
        begin
            if (enc_mode || in_last)
            begin
                phase_next = PH_IDLE;
                held_next  = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (in_byte == CH_PERCENT)
                            phase_next = PH_PCT;
                    end
                    PH_PCT:
                    begin
                        phase_next = PH_DIGIT;
                        held_next  = in_byte;
                    end
                    PH_DIGIT:
                    begin
                        phase_next = PH_IDLE;
                        held_next  = 8'd0;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        held_next  = 8'd0;
                    end
                endcase
            end
        end
    end

    // outputs: coded group for the current byte
    always_comb
    begin
        q_cmd      = '0;
        q_cmd.last = in_last;
        if (enc_mode)
        begin
            if (is_unreserved(in_byte) ||
                (mode_reg == MODE_REQUOTE && is_reserved(in_byte)))
            begin
                q_cmd.cnt = 2'd1;
                q_cmd.b0  = in_byte;
            end
            else
            begin
                q_cmd.cnt = 2'd3;
                q_cmd.b0  = CH_PERCENT;
                q_cmd.b1  = hex_digit(in_byte[7:4]);
                q_cmd.b2  = hex_digit(in_byte[3:0]);
            end
        end
        else
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (in_last)
                    begin
                        q_cmd.cnt = 2'd2;
                        q_cmd.b0  = CH_PERCENT;
                        q_cmd.b1  = plain;
                    end
                end
                PH_DIGIT:
                begin
                    if (mode_reg == MODE_DECODE || is_unreserved(dec_val))
                    begin
                        q_cmd.cnt = 2'd1;
                        q_cmd.b0  = dec_val;
                    end
                    else
                    begin
                        q_cmd.cnt = 2'd3;
                        q_cmd.b0  = CH_PERCENT;
                        q_cmd.b1  = held_reg;
                        q_cmd.b2  = in_byte;
                    end
                end
                default:
                begin
                    if (in_byte == CH_PERCENT)
                    begin
                        if (in_last)
                        begin
                            q_cmd.cnt = 2'd1;
                            q_cmd.b0  = CH_PERCENT;
                        end
                    end
                    else
                    begin
                        q_cmd.cnt = 2'd1;
                        q_cmd.b0  = plain;
                    end
                end
            endcase
        end
    end

    // bytes that only open an escape produce nothing
    assign q_push = accept && (q_cmd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENCODE;
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

/* design/upce_queue.sv */
module upce_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  upce_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output upce_pkg::cmd_t head_cmd
);
    import upce_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/upce_back.sv */
module upce_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  upce_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last
);
    import upce_pkg::*;

    cmd_t       cmd_reg, cmd_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    cmd_t       src;
    logic [1:0] src_idx;
    logic       have;
    logic       out_load;
    logic       step;
    logic       final_byte;
    logic [7:0] sel_byte;

    // a fresh group is served straight from the queue head
    assign src        = busy_reg ? cmd_reg : q_cmd;
    assign src_idx    = busy_reg ? idx_reg : 2'd0;
    assign have       = busy_reg || q_valid;
    assign out_load   = !out_valid_reg || out_ready;
    assign step       = out_load && have;
    assign final_byte = (src_idx == (src.cnt - 2'd1));
    assign q_pop      = step && !busy_reg;

    always_comb
    begin
        case (src_idx)
            2'd1:    sel_byte = src.b1;
            2'd2:    sel_byte = src.b2;
            default: sel_byte = src.b0;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (out_load)
            out_valid_next = have;
        if (step)
        begin
            out_byte_next = sel_byte;
            out_last_next = src.last && final_byte;
            busy_next     = !final_byte;
            idx_next      = final_byte ? 2'd0 : src_idx + 2'd1;
            if (!busy_reg)
                cmd_next = q_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

/* design/url_percent_coding_engine_unit.sv */
// Channel   Signals                                 Dir   Word
// cfg       cfg_valid / cfg_ready, coding_mode      in    coding mode (2 bits)
// in        in_valid / in_ready, in_byte, in_last   in    one input byte, end mark
// out       out_valid / out_ready, out_byte, out_last out  one coded byte, end mark
//
// Each input word expands to 0..3 output words (3 for a percent-encoded byte);
// the output register sends one word per cycle while out_ready allows.
// Input words are taken every cycle while the group queue has room.
// Reset clears mode (encode), escape state, queue and output valid.
// Stalls on out_ready back up through the queue to in_ready only.
module url_percent_coding_engine_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] coding_mode,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);
    import upce_pkg::*;

    // front -> queue -> back
    logic q_full;
    logic q_push;
    cmd_t q_in_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head_cmd;

    // classify bytes and track the pending escape
    upce_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .coding_mode (coding_mode),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_in_cmd)
    );

    // short queue of coded groups so each side stalls on its own
    upce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_in_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    // serialize each group into output words
    upce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule
